// ===== rtl/shc_pkg.sv =====
// Package for the substring hash engine: item types, modular constants
// and small modular add, subtract and multiply-step helpers.
// Depends on nothing.
package shc_pkg;

    localparam logic [31:0] MOD1 = 32'd1000000007;
    localparam logic [31:0] MOD2 = 32'd1000000009;
    localparam logic [29:0] BASE1 = 30'd137;
    localparam logic [29:0] BASE2 = 30'd277;
    localparam logic [29:0] INV1 = 30'd58394161;
    localparam logic [29:0] INV2 = 30'd494584842;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [4:0] IDX_BYTE = 5'd7;
    localparam logic [4:0] IDX_BASE = 5'd8;
    localparam logic [4:0] IDX_FULL = 5'd29;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [11:0] query_start;
        logic [11:0] query_end;
    } t_in;

    typedef struct packed {
        logic [29:0] hash_first;
        logic [29:0] hash_second;
        logic [1:0]  status;
        logic [12:0] string_length;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [29:0] a1;
        logic [29:0] a2;
        logic [29:0] b1;
        logic [29:0] b2;
        logic [4:0]  top_idx;
    } t_mm_req;

    typedef struct packed {
        logic        done;
        logic [29:0] p1;
        logic [29:0] p2;
    } t_mm_rsp;

    function automatic logic [29:0] mm_step(input logic [29:0] acc, input logic [29:0] a,
                                            input logic bt, input logic [31:0] m);
        logic [31:0] t;
        logic [31:0] m2;
        m2 = {m[30:0], 1'b0};
        t = {1'b0, acc, 1'b0} + (bt ? {2'b00, a} : 32'd0);
        if (t >= m2) begin
            t = t - m2;
        end else if (t >= m) begin
            t = t - m;
        end
        return t[29:0];
    endfunction

    function automatic logic [29:0] add_mod(input logic [29:0] x, input logic [29:0] y,
                                            input logic [31:0] m);
        logic [31:0] s;
        s = {2'b00, x} + {2'b00, y};
        if (s >= m) begin
            s = s - m;
        end
        return s[29:0];
    endfunction

    function automatic logic [29:0] sub_mod(input logic [29:0] x, input logic [29:0] y,
                                            input logic [31:0] m);
        logic [31:0] s;
        s = {2'b00, x} + m - {2'b00, y};
        if (s >= m) begin
            s = s - m;
        end
        return s[29:0];
    endfunction

endpackage

// ===== rtl/shc_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// Depends on nothing.
module shc_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/shc_mulmod.sv =====
// Bit-serial modular multiplier with one lane per modulus.
// Depends on shc_pkg for the request and response types and helpers.
module shc_mulmod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  shc_pkg::t_mm_req i_req,
    output shc_pkg::t_mm_rsp o_rsp
);
    import shc_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_idx;
    logic [29:0] r_acc1, r_acc2, r_a1, r_a2, r_b1, r_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_idx  <= i_req.top_idx;
                r_acc1 <= '0;
                r_acc2 <= '0;
                r_a1   <= i_req.a1;
                r_a2   <= i_req.a2;
                r_b1   <= i_req.b1;
                r_b2   <= i_req.b2;
            end else if (r_busy) begin
                r_acc1 <= mm_step(r_acc1, r_a1, r_b1[r_idx], MOD1);
                r_acc2 <= mm_step(r_acc2, r_a2, r_b2[r_idx], MOD2);
                r_idx  <= r_idx - 5'd1;
                r_done <= (r_idx == 5'd0);
                if (r_idx == 5'd0) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p1   = r_acc1;
    assign o_rsp.p2   = r_acc2;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("product without a running multiply");
    a_p1_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({2'b00, r_acc1} < MOD1)) else $error("first product not reduced");
    a_p2_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({2'b00, r_acc2} < MOD2)) else $error("second product not reduced");
endmodule

// ===== rtl/substring_hash_engine_unit.sv =====
// Substring hash engine top level: double polynomial hash over a byte string.
// Append, query, clear and no-op items are handled one item at a time.
// The bit-serial modular multiplier behind append and query works one bit per cycle.
// After reset the inverse power table is built; the unit is not ready until that is done.
// Reset empties the string. Depends on shc_pkg, shc_ram and shc_mulmod.
module substring_hash_engine_unit #(
    parameter int MAX_LEN = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  shc_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output shc_pkg::t_out o_item
);
    import shc_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = ((LW > 12) ? LW : 12) + 1;
    localparam logic [AW-1:0] LAST_B = AW'(MAX_LEN - 2);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_BSTART = 4'd1;
    localparam logic [3:0] S_BWAIT  = 4'd2;
    localparam logic [3:0] S_IDLE   = 4'd3;
    localparam logic [3:0] S_AMUL   = 4'd4;
    localparam logic [3:0] S_AWAIT  = 4'd5;
    localparam logic [3:0] S_PMUL   = 4'd6;
    localparam logic [3:0] S_PWAIT  = 4'd7;
    localparam logic [3:0] S_Q1     = 4'd8;
    localparam logic [3:0] S_Q2     = 4'd9;
    localparam logic [3:0] S_Q3     = 4'd10;
    localparam logic [3:0] S_Q4     = 4'd11;
    localparam logic [3:0] S_QWAIT  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]    r_state;
    logic [LW-1:0] r_len;
    logic [29:0]   r_pow1, r_pow2, r_ip1, r_ip2, r_h1, r_h2, r_x1, r_x2;
    logic [1:0]    r_st;
    logic [AW-1:0] r_baddr, r_raddr, r_iraddr;
    logic [7:0]    r_byte;
    logic [11:0]   r_qs;
    logic          r_ovalid;
    t_out          r_out;

    t_mm_req       mm_req;
    t_mm_rsp       mm_rsp;
    logic [59:0]   p_rd, i_rd, p_wd, i_wd;
    logic          p_we, i_we;
    logic [AW-1:0] p_wa, i_wa, b_next;
    logic [LW-1:0] len_m1;
    logic [AW+11:0] qe_w, qs_w, qsm1_w;
    logic [LW+12:0] len_w;
    logic          full, q_ok;
    logic [29:0]   s1, s2, d1, d2;

    shc_mulmod u_mm (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mm_req), .o_rsp(mm_rsp));

    shc_ram #(.WIDTH(60), .DEPTH(MAX_LEN)) u_pref (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(r_raddr), .o_rdata(p_rd));

    shc_ram #(.WIDTH(60), .DEPTH(MAX_LEN)) u_inv (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_wa), .i_wdata(i_wd),
        .i_raddr(r_iraddr), .o_rdata(i_rd));

    assign len_m1 = r_len - LW'(1);
    assign qe_w   = {AW'(0), i_item.query_end};
    assign qs_w   = {AW'(0), i_item.query_start};
    assign qsm1_w = {AW'(0), r_qs - 12'd1};
    assign len_w  = {13'd0, r_len};
    assign full   = (r_len == LW'(MAX_LEN));
    assign q_ok   = (i_item.query_start <= i_item.query_end) &&
                    (CW'(i_item.query_end) < CW'(r_len));
    assign b_next = r_baddr + AW'(1);

    assign s1 = (r_len != '0) ? add_mod(mm_rsp.p1, p_rd[29:0], MOD1) : mm_rsp.p1;
    assign s2 = (r_len != '0) ? add_mod(mm_rsp.p2, p_rd[59:30], MOD2) : mm_rsp.p2;
    assign d1 = (r_qs != 12'd0) ? sub_mod(r_x1, p_rd[29:0], MOD1) : r_x1;
    assign d2 = (r_qs != 12'd0) ? sub_mod(r_x2, p_rd[59:30], MOD2) : r_x2;

    assign p_we = (r_state == S_AWAIT) && mm_rsp.done;
    assign p_wa = r_len[AW-1:0];
    assign p_wd = {s2, s1};

    assign i_we = (r_state == S_INIT) || ((r_state == S_BWAIT) && mm_rsp.done);
    assign i_wa = (r_state == S_INIT) ? '0 : b_next;
    assign i_wd = (r_state == S_INIT) ? {30'd1, 30'd1} : {mm_rsp.p2, mm_rsp.p1};

    always_comb begin
        mm_req = '0;
        case (r_state)
            S_BSTART: begin
                mm_req = '{1'b1, r_ip1, r_ip2, INV1, INV2, IDX_FULL};
            end
            S_AMUL: begin
                mm_req = '{1'b1, r_pow1, r_pow2, {22'd0, r_byte}, {22'd0, r_byte}, IDX_BYTE};
            end
            S_PMUL: begin
                mm_req = '{1'b1, r_pow1, r_pow2, BASE1, BASE2, IDX_BASE};
            end
            S_Q4: begin
                mm_req = '{1'b1, d1, d2, i_rd[29:0], i_rd[59:30], IDX_FULL};
            end
            default: begin
                mm_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_len    <= '0;
            r_pow1   <= 30'd1;
            r_pow2   <= 30'd1;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_ip1   <= 30'd1;
                    r_ip2   <= 30'd1;
                    r_baddr <= '0;
                    r_state <= S_BSTART;
                end
                S_BSTART: begin
                    r_state <= S_BWAIT;
                end
                S_BWAIT: begin
                    if (mm_rsp.done) begin
                        r_ip1   <= mm_rsp.p1;
                        r_ip2   <= mm_rsp.p2;
                        r_baddr <= b_next;
                        r_state <= (r_baddr == LAST_B) ? S_IDLE : S_BSTART;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_h1    <= '0;
                        r_h2    <= '0;
                        r_byte  <= i_item.char_code;
                        r_qs    <= i_item.query_start;
                        case (i_item.operation)
                            OP_APPEND: begin
                                if (full) begin
                                    r_st    <= ST_FULL;
                                    r_state <= S_OUT;
                                end else begin
                                    r_st    <= ST_OK;
                                    r_raddr <= len_m1[AW-1:0];
                                    r_state <= S_AMUL;
                                end
                            end
                            OP_QUERY: begin
                                if (!q_ok) begin
                                    r_st    <= ST_RANGE;
                                    r_state <= S_OUT;
                                end else begin
                                    r_st     <= ST_OK;
                                    r_raddr  <= qe_w[AW-1:0];
                                    r_iraddr <= qs_w[AW-1:0];
                                    r_state  <= S_Q1;
                                end
                            end
                            OP_CLEAR: begin
                                r_st    <= ST_OK;
                                r_len   <= '0;
                                r_pow1  <= 30'd1;
                                r_pow2  <= 30'd1;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_st    <= ST_OK;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_AMUL: begin
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    if (mm_rsp.done) begin
                        r_h1    <= s1;
                        r_h2    <= s2;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (mm_rsp.done) begin
                        r_pow1  <= mm_rsp.p1;
                        r_pow2  <= mm_rsp.p2;
                        r_len   <= r_len + LW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_Q1: begin
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    r_x1    <= p_rd[29:0];
                    r_x2    <= p_rd[59:30];
                    r_raddr <= qsm1_w[AW-1:0];
                    r_state <= S_Q3;
                end
                S_Q3: begin
                    r_state <= S_Q4;
                end
                S_Q4: begin
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (mm_rsp.done) begin
                        r_h1    <= mm_rsp.p1;
                        r_h2    <= mm_rsp.p2;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_out    <= '{r_h1, r_h2, r_st, len_w[12:0]};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_len) <= CW'(MAX_LEN)) else $error("string length beyond store");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.status != ST_OK) |->
        (r_out.hash_first == '0 && r_out.hash_second == '0))
        else $error("flagged item carries a hash");
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.status == ST_FULL) |-> (r_out.string_length == 13'(MAX_LEN)))
        else $error("full store reported with changed length");
endmodule

// ===== tb/sv/tb_substring_hash_engine_unit.sv =====
`timescale 1ns / 100ps
// Testbench for substring_hash_engine_unit: a queue-fed driver and a monitor that checks
// every result against a double polynomial hash predictor kept in the testbench.
// Depends on shc_pkg and the substring hash engine RTL.
module tb_substring_hash_engine_unit;
    import shc_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam logic [1:0] OP_IDLE = 2'd3;
    localparam longint LIMIT_CYCLES = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in i_item = '0;
    logic o_ready;
    logic o_valid;
    t_out o_item;

    substring_hash_engine_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    always #4 i_clk = ~i_clk;

    t_in pending_items[$];
    t_out expected_hashes[$];
    longint unsigned prefix_a[STORE_DEPTH];
    longint unsigned prefix_b[STORE_DEPTH];
    longint unsigned inv_pow_a[STORE_DEPTH];
    longint unsigned inv_pow_b[STORE_DEPTH];
    longint unsigned power_a;
    longint unsigned power_b;
    int unsigned string_len;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    longint cycle_count = 0;

    function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        acc = 1;
        while (e != 0) begin
            if (e[0]) begin
                acc = (acc * b) % m;
            end
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    task automatic build_inverse_tables();
        longint unsigned ia;
        longint unsigned ib;
        longint unsigned step_a;
        longint unsigned step_b;
        step_a = mod_pow(64'd137, 64'd1000000005, 64'd1000000007);
        step_b = mod_pow(64'd277, 64'd1000000007, 64'd1000000009);
        ia = 1;
        ib = 1;
        for (int p = 0; p < STORE_DEPTH; p++) begin
            inv_pow_a[p] = ia;
            inv_pow_b[p] = ib;
            ia = (ia * step_a) % 64'd1000000007;
            ib = (ib * step_b) % 64'd1000000009;
        end
        power_a = 1;
        power_b = 1;
        string_len = 0;
    endtask

    function automatic t_out predict_hash(t_in it);
        t_out r;
        longint unsigned h1;
        longint unsigned h2;
        int unsigned qs;
        int unsigned qe;
        r = '0;
        qs = 32'(it.query_start);
        qe = 32'(it.query_end);
        case (it.operation)
            OP_APPEND: begin
                if (string_len >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    h1 = (it.char_code * power_a) % 64'd1000000007;
                    h2 = (it.char_code * power_b) % 64'd1000000009;
                    if (string_len != 0) begin
                        h1 = (h1 + prefix_a[string_len - 1]) % 64'd1000000007;
                        h2 = (h2 + prefix_b[string_len - 1]) % 64'd1000000009;
                    end
                    prefix_a[string_len] = h1;
                    prefix_b[string_len] = h2;
                    power_a = (power_a * 137) % 64'd1000000007;
                    power_b = (power_b * 277) % 64'd1000000009;
                    string_len++;
                    r.hash_first = h1[29:0];
                    r.hash_second = h2[29:0];
                end
            end
            OP_QUERY: begin
                if (qs > qe || qe >= string_len) begin
                    r.status = ST_RANGE;
                end else begin
                    h1 = prefix_a[qe];
                    h2 = prefix_b[qe];
                    if (qs != 0) begin
                        h1 = (h1 + 64'd1000000007 - prefix_a[qs - 1]) % 64'd1000000007;
                        h2 = (h2 + 64'd1000000009 - prefix_b[qs - 1]) % 64'd1000000009;
                    end
                    h1 = (h1 * inv_pow_a[qs]) % 64'd1000000007;
                    h2 = (h2 * inv_pow_b[qs]) % 64'd1000000009;
                    r.hash_first = h1[29:0];
                    r.hash_second = h2[29:0];
                end
            end
            OP_CLEAR: begin
                string_len = 0;
                power_a = 1;
                power_b = 1;
            end
            default: begin
            end
        endcase
        r.string_length = string_len[12:0];
        return r;
    endfunction

    function automatic t_in make_item(logic [1:0] op, logic [7:0] ch, int qs, int qe);
        t_in it;
        it.operation = op;
        it.char_code = ch;
        it.query_start = qs[11:0];
        it.query_end = qe[11:0];
        return it;
    endfunction

    // The model length is tracked here so that random queries mostly hit the loaded range.
    int unsigned gen_len = 0;

    task automatic queue_item(t_in it);
        pending_items.push_back(it);
        if (it.operation == OP_APPEND && gen_len < STORE_DEPTH) begin
            gen_len++;
        end else if (it.operation == OP_CLEAR) begin
            gen_len = 0;
        end
    endtask

    task automatic queue_random_item();
        int pick;
        int qs;
        int qe;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            queue_item(make_item(OP_APPEND, 8'($urandom), $urandom, $urandom));
        end else if (pick < 85 && gen_len > 0) begin
            qs = $urandom_range(0, gen_len - 1);
            qe = $urandom_range(qs, gen_len - 1);
            queue_item(make_item(OP_QUERY, 8'($urandom), qs, qe));
        end else if (pick < 93) begin
            queue_item(make_item(OP_QUERY, 8'($urandom), $urandom, $urandom));
        end else if (pick < 97) begin
            queue_item(make_item(OP_IDLE, 8'($urandom), $urandom, $urandom));
        end else begin
            queue_item(make_item(OP_CLEAR, 8'($urandom), $urandom, $urandom));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_valid || expected_hashes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_hashes.push_back(predict_hash(i_item));
            end
            if (!i_valid || o_ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_item <= pending_items.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out exp_item;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_hashes.size() == 0) begin
                $error("unexpected result %h", o_item);
                fail_count++;
            end else begin
                exp_item = expected_hashes.pop_front();
                if (o_item.hash_first !== exp_item.hash_first) begin
                    $error("hash_first expected %0d got %0d",
                           exp_item.hash_first, o_item.hash_first);
                    fail_count++;
                end
                if (o_item.hash_second !== exp_item.hash_second) begin
                    $error("hash_second expected %0d got %0d",
                           exp_item.hash_second, o_item.hash_second);
                    fail_count++;
                end
                if (o_item.status !== exp_item.status) begin
                    $error("status expected %0d got %0d", exp_item.status, o_item.status);
                    fail_count++;
                end
                if (o_item.string_length !== exp_item.string_length) begin
                    $error("string_length expected %0d got %0d",
                           exp_item.string_length, o_item.string_length);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        build_inverse_tables();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-string cases, field extremes, a full store and a wrap back.
        queue_item(make_item(OP_QUERY, 8'h00, 0, 0));
        queue_item(make_item(OP_APPEND, 8'hFF, 4095, 4095));
        queue_item(make_item(OP_APPEND, 8'h00, 0, 0));
        queue_item(make_item(OP_APPEND, 8'h80, 0, 0));
        queue_item(make_item(OP_APPEND, 8'h7F, 0, 0));
        queue_item(make_item(OP_QUERY, 8'hFF, 0, 3));
        queue_item(make_item(OP_QUERY, 8'h00, 1, 2));
        queue_item(make_item(OP_QUERY, 8'h00, 3, 3));
        queue_item(make_item(OP_QUERY, 8'h00, 2, 1));
        queue_item(make_item(OP_QUERY, 8'h00, 0, 4));
        queue_item(make_item(OP_QUERY, 8'h00, 4095, 4095));
        queue_item(make_item(OP_IDLE, 8'hAA, 1365, 2730));
        queue_item(make_item(OP_CLEAR, 8'h55, 2730, 1365));
        queue_item(make_item(OP_QUERY, 8'h00, 0, 0));
        for (int k = 0; k < STORE_DEPTH; k++) begin
            queue_item(make_item(OP_APPEND, 8'($urandom), $urandom, $urandom));
        end
        queue_item(make_item(OP_APPEND, 8'h12, 0, 0));
        queue_item(make_item(OP_QUERY, 8'h00, 0, 4095));
        queue_item(make_item(OP_QUERY, 8'h00, 4095, 4095));
        queue_item(make_item(OP_QUERY, 8'h00, 2048, 4094));
        queue_item(make_item(OP_CLEAR, 8'h00, 0, 0));
        queue_item(make_item(OP_APPEND, 8'h01, 0, 0));
        queue_item(make_item(OP_QUERY, 8'h00, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 80) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 80) : 0;
            for (int k = 0; k < 175; k++) begin
                queue_random_item();
            end
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && expected_hashes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
